@@ src/bsr_pkg.sv @@
// Shared types and constants for the buffer swap ring manager.
// No dependencies; imported by bsr_ctrl and the top level.
`timescale 1ns / 1ps

package bsr_pkg;

    localparam int MAX_NODES_DEF  = 8;
    localparam int NODE_COUNT_RST = 3;
    localparam int CFG_AW         = 3;

    // register index, taken from paddr above the byte offset
    localparam logic [CFG_AW-3:0] REG_NODE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_BORROW_WR = 2'd0,
        OP_RETURN_WR = 2'd1,
        OP_BORROW_RD = 2'd2,
        OP_RETURN_RD = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOK,
        ST_LINK,
        ST_RET,
        ST_POST
    } state_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [2:0] node_id;
    } req_word_t;

    typedef struct packed {
        logic       granted;
        logic [2:0] granted_node;
    } rsp_word_t;

endpackage

@@ src/bsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/bsr_ctrl.sv @@
// Sequencer for the ring: link tables in two RAMs, cursor, output register.
// Depends on bsr_pkg and bsr_ram.
`timescale 1ns / 1ps

module bsr_ctrl #(
    parameter int MAX_NODES = bsr_pkg::MAX_NODES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rebuild,
    input  logic [$clog2(MAX_NODES+1)-1:0]   count,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  bsr_pkg::req_word_t               req_word,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output bsr_pkg::rsp_word_t               rsp_word
);

    import bsr_pkg::*;

    localparam int LW = $clog2(MAX_NODES);
    localparam logic [LW-1:0] LAST_IDX = LW'(MAX_NODES - 1);

    state_t       state_reg, state_next;
    logic [LW-1:0] cur_reg, cur_next;
    opcode_t      op_reg, op_next;
    logic [2:0]   id_reg, id_next;
    logic [LW-1:0] taken_reg, taken_next;
    logic [LW-1:0] q_reg, q_next;
    logic [LW-1:0] sweep_reg, sweep_next;
    rsp_word_t    res_reg, res_next;
    rsp_word_t    rsp_reg, rsp_next;
    logic         rsp_valid_reg, rsp_valid_next;

    logic          n_we, p_we;
    logic [LW-1:0] n_waddr, n_wdata, n_raddr, n_rdata;
    logic [LW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic [LW-1:0] t_sel, id_idx;
    logic          id_ok;

    bsr_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_next_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    bsr_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_prev_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign id_idx    = LW'(id_reg);
    assign id_ok     = 32'(id_reg) < 32'(count);
    assign t_sel     = (op_reg == OP_BORROW_WR) ? n_rdata : cur_reg;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            cur_reg       <= '0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        id_reg    <= id_next;
        taken_reg <= taken_next;
        q_reg     <= q_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        taken_next     = taken_reg;
        q_next         = q_reg;
        sweep_next     = sweep_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        n_we           = 1'b0;
        p_we           = 1'b0;
        n_waddr        = '0;
        n_wdata        = '0;
        p_waddr        = '0;
        p_wdata        = '0;
        n_raddr        = cur_reg;
        p_raddr        = cur_reg;

        case (state_reg)
            ST_SWEEP:
            begin
                // in-order ring over count entries, zeros above
                n_we    = 1'b1;
                p_we    = 1'b1;
                n_waddr = sweep_reg;
                p_waddr = sweep_reg;
                if (32'(sweep_reg) < 32'(count))
                begin
                    n_wdata = (32'(sweep_reg) + 32'd1 == 32'(count)) ? '0 : sweep_reg + 1'b1;
                    p_wdata = (sweep_reg == '0) ? LW'(count - 1'b1) : sweep_reg - 1'b1;
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_IDX)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req_word.opcode;
                    id_next    = req_word.node_id;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // n_rdata holds next of the cursor
                res_next = '0;
                if (op_reg inside {OP_BORROW_WR, OP_BORROW_RD})
                begin
                    if (n_rdata == cur_reg)
                    begin
                        state_next = ST_POST;
                    end
                    else
                    begin
                        n_raddr    = t_sel;
                        p_raddr    = t_sel;
                        taken_next = t_sel;
                        state_next = ST_LINK;
                    end
                end
                else if (!id_ok)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    q_next     = n_rdata;
                    n_we       = 1'b1;
                    n_waddr    = cur_reg;
                    n_wdata    = id_idx;
                    p_we       = 1'b1;
                    p_waddr    = id_idx;
                    p_wdata    = cur_reg;
                    state_next = ST_RET;
                end
            end
            ST_LINK:
            begin
                // unlink taken: next[prev] = next, prev[next] = prev
                n_we     = 1'b1;
                n_waddr  = p_rdata;
                n_wdata  = n_rdata;
                p_we     = 1'b1;
                p_waddr  = n_rdata;
                p_wdata  = p_rdata;
                if (op_reg == OP_BORROW_RD)
                begin
                    cur_next = n_rdata;
                end
                res_next.granted      = 1'b1;
                res_next.granted_node = 3'(taken_reg);
                state_next = ST_POST;
            end
            ST_RET:
            begin
                n_we    = 1'b1;
                n_waddr = id_idx;
                n_wdata = q_reg;
                p_we    = 1'b1;
                p_waddr = q_reg;
                p_wdata = id_idx;
                if (op_reg == OP_RETURN_WR)
                begin
                    cur_next = id_idx;
                end
                state_next = ST_POST;
            end
            ST_POST:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
                sweep_next = '0;
            end
        endcase

        if (rebuild)
        begin
            state_next = ST_SWEEP;
            sweep_next = '0;
            cur_next   = '0;
        end
    end

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !rebuild) |=> state_reg == ST_LOOK)
        else $error("accepted word did not start the table lookup");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> 32'(cur_reg) < 32'(count))
        else $error("cursor outside the ring");

    a_post_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POST && rsp_valid_reg && rsp_stall && !rebuild)
            |=> state_reg == ST_POST)
        else $error("result left before the output register was free");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.granted) |-> rsp_reg.granted_node == 3'd0)
        else $error("node reported without a grant");

endmodule

@@ src/buffer_swap_ring_manager_top.sv @@
// Top level of the buffer swap ring manager: APB register port and sequencer.
// Depends on bsr_pkg, bsr_ctrl and bsr_ram.
`timescale 1ns / 1ps

// Hands out and takes back buffer nodes kept in a circular doubly linked
// ring (next and prev tables in two small RAMs) with a cursor. Each request
// word goes from acceptance to a loaded result through ST_LOOK (read next
// of the cursor; a borrow also issues its second link read), ST_LINK or
// ST_RET (link writes) and ST_POST (load the output register). A refused
// borrow or an ignored return skips the link step. req_stall is high from
// acceptance until the result is loaded, so a new word is accepted only
// after the last one's result is loaded, and the load waits while an
// earlier result is still held by rsp_stall. The single read and write
// port of each link RAM is why the link accesses are spread over states.
// The result register lets the next request be accepted while a result
// waits. After reset and after every node_count write, the tables are
// rebuilt by an init sweep over all MAX_NODES entries, during which
// req_stall stays high. node_count is clamped to 1..MAX_NODES; a return of
// a node at or above node_count is ignored and answered with granted = 0.
module buffer_swap_ring_manager_top #(
    parameter int MAX_NODES = bsr_pkg::MAX_NODES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bsr_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  bsr_pkg::req_word_t         req_word,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output bsr_pkg::rsp_word_t         rsp_word
);

    import bsr_pkg::*;

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] COUNT_RST =
        CW'((NODE_COUNT_RST > MAX_NODES) ? MAX_NODES : NODE_COUNT_RST);

    logic [CW-1:0] count_reg, count_next;
    logic          reg_hit, cfg_wr;
    logic [3:0]    wval;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[CFG_AW-1:2] == REG_NODE_COUNT);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign prdata  = reg_hit ? 32'(count_reg) : 32'd0;
    assign wval    = pwdata[3:0];

    always_comb
    begin
        count_next = count_reg;
        if (cfg_wr)
        begin
            if (wval == 4'd0)
            begin
                count_next = CW'(1);
            end
            else if (32'(wval) > MAX_NODES)
            begin
                count_next = CW'(MAX_NODES);
            end
            else
            begin
                count_next = CW'(wval);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RST;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    bsr_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rebuild   (cfg_wr),
        .count     (count_reg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule
